/* design/sdspi_pkg.sv */
// shared constants and result type for the sd spi command engine
package sdspi_pkg;

	// phase codes
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_CMD   = 4'd1;
	localparam logic [3:0] PH_FILL  = 4'd2;
	localparam logic [3:0] PH_POLL  = 4'd3;
	localparam logic [3:0] PH_BUSY  = 4'd4;
	localparam logic [3:0] PH_R2    = 4'd5;
	localparam logic [3:0] PH_R7    = 4'd6;
	localparam logic [3:0] PH_TRAIL = 4'd7;

	// response kinds
	localparam logic [1:0] KIND_R1  = 2'd0;
	localparam logic [1:0] KIND_R1B = 2'd1;
	localparam logic [1:0] KIND_R2  = 2'd2;
	localparam logic [1:0] KIND_R7  = 2'd3;

	// item codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_RX    = 1'b1;

	localparam logic [7:0]  START_TOKEN   = 8'h40;
	localparam logic [7:0]  CRC_CMD0      = 8'h95;
	localparam logic [7:0]  FILL_BYTE     = 8'hFF;
	localparam logic [7:0]  IDLE_BYTE     = 8'h00;
	localparam logic [15:0] R1_PREFIX     = 16'hFF00;
	localparam logic [7:0]  RETRY_RESET   = 8'd200;
	localparam logic [2:0]  LAST_FRAME    = 3'd5;
	localparam logic [2:0]  LAST_R7       = 3'd4;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        cs_low;
		logic        done_res;
		logic        timed_out;
		logic [15:0] response;
		logic [31:0] extra_response;
	} res_t;

endpackage

/* design/sd_spi_command_engine_unit.sv */
// sd card spi-mode command engine: frame sender and response collector
//
// usage
//   input channel (in_valid / in_stall): one transfer per byte event. cmd = 0
//   starts a command (index, argument, crc choice, response kind, chip select
//   hold); cmd = 1 hands over rx_byte, the byte received for the last byte sent.
//   output channel (out_valid / out_stall): one result transfer per input
//   transfer, carrying the next byte to shift out, the chip select level and,
//   on the last item of a sequence, done_res with the response fields.
//   the user writes retry_limit (cfg_wr_en / cfg_wr_data) only while idle; not enforced.
// result path and throughput
//   each result is registered; one item per cycle sustained while out_stall is low.
//   the state update is one short pass of logic into the result register.
// reset
//   arst_n low clears the phase, the latched command and the valid flags of both
//   output stages; retry_limit returns to 200 and the chip select state to deasserted.
// stall
//   a result held by out_stall stays in the output register; one more item
//   is still taken into the skid stage, after which in_stall rises until the
//   output drains.
module sd_spi_command_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [5:0]  cmd_index,
	input  logic [31:0] cmd_arg,
	input  logic [7:0]  crc_byte,
	input  logic        auto_crc,
	input  logic [1:0]  resp_kind,
	input  logic        keep_cs_low,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        cs_low,
	output logic        done_res,
	output logic        timed_out,
	output logic [15:0] response,
	output logic [31:0] extra_response
);
	import sdspi_pkg::*;

	// command state
	logic [7:0]  retry_limit_q;
	logic [3:0]  phase_q;
	logic [2:0]  byte_count_q;
	logic [7:0]  tries_left_q;
	logic [5:0]  index_q;
	logic [31:0] arg_q;
	logic [7:0]  crc_q;
	logic [1:0]  kind_q;
	logic        keep_q;
	logic [15:0] resp_value_q;
	logic [31:0] resp_extra_q;
	logic        cs_q;
	logic        tmo_q;

	// next state
	logic [3:0]  phase_d;
	logic [2:0]  byte_count_d;
	logic [7:0]  tries_left_d;
	logic [5:0]  index_d;
	logic [31:0] arg_d;
	logic [7:0]  crc_d;
	logic [1:0]  kind_d;
	logic        keep_d;
	logic [15:0] resp_value_d;
	logic [31:0] resp_extra_d;
	logic        cs_d;
	logic        tmo_d;

	// output stage and skid stage
	res_t res_d;
	res_t out_s1;
	res_t skid_s1;
	logic out_v_q;
	logic skid_v_q;

	logic       accept;
	logic       take;
	logic       emit_valid;
	logic [7:0] emit_byte;
	logic       emit_done;
	logic [7:0] load_tries;
	logic [2:0] bc_inc;
	logic [7:0] tries_dec;

	assign accept    = in_valid && !in_stall;
	assign take      = out_v_q && !out_stall;
	assign in_stall  = skid_v_q;
	assign out_valid = out_v_q;

	// a zero limit still gives one read
	assign load_tries = (retry_limit_q == 8'd0) ? 8'd1 : retry_limit_q;
	assign bc_inc     = byte_count_q + 3'd1;
	assign tries_dec  = tries_left_q - 8'd1;

	// frame byte for the current position within the command
	function automatic logic [7:0] frame_byte(input logic [2:0] n, input logic [5:0] idx,
			input logic [31:0] arg, input logic [7:0] crc);
		logic [7:0] b;
		unique case (n)
			3'd0:    b = START_TOKEN | {2'b00, idx};
			3'd1:    b = arg[31:24];
			3'd2:    b = arg[23:16];
			3'd3:    b = arg[15:8];
			3'd4:    b = arg[7:0];
			default: b = crc;
		endcase
		return b;
	endfunction

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		tries_left_d = tries_left_q;
		index_d      = index_q;
		arg_d        = arg_q;
		crc_d        = crc_q;
		kind_d       = kind_q;
		keep_d       = keep_q;
		resp_value_d = resp_value_q;
		resp_extra_d = resp_extra_q;
		cs_d         = cs_q;
		tmo_d        = tmo_q;
		emit_valid   = 1'b1;
		emit_byte    = FILL_BYTE;
		emit_done    = 1'b0;

		if (cmd == CMD_START) begin
			// a start abandons whatever was running
			index_d      = cmd_index;
			arg_d        = cmd_arg;
			if (auto_crc)
				crc_d = (cmd_index == 6'd0) ? CRC_CMD0 : FILL_BYTE;
			else
				crc_d = crc_byte;
			kind_d       = resp_kind;
			keep_d       = keep_cs_low;
			resp_value_d = 16'h0000;
			resp_extra_d = 32'h0000_0000;
			tmo_d        = 1'b0;
			tries_left_d = 8'd0;
			cs_d         = 1'b1;
			phase_d      = PH_CMD;
			byte_count_d = 3'd0;
			emit_byte    = frame_byte(3'd0, cmd_index, cmd_arg, crc_d);
		end else begin
			unique case (phase_q)
				PH_CMD: begin
					byte_count_d = bc_inc;
					if (bc_inc <= LAST_FRAME)
						emit_byte = frame_byte(bc_inc, index_q, arg_q, crc_q);
					else
						phase_d = PH_FILL;
				end
				PH_FILL: begin
					byte_count_d = 3'd0;
					if (kind_q == KIND_R1 || kind_q == KIND_R1B) begin
						phase_d      = PH_POLL;
						tries_left_d = load_tries;
					end else begin
						phase_d = (kind_q == KIND_R2) ? PH_R2 : PH_R7;
					end
				end
				PH_POLL: begin
					tries_left_d = tries_dec;
					resp_value_d = R1_PREFIX | {8'h00, rx_byte};
					if (rx_byte != FILL_BYTE || tries_dec == 8'd0) begin
						if (rx_byte == FILL_BYTE)
							tmo_d = 1'b1;
						if (kind_q == KIND_R1B) begin
							phase_d      = PH_BUSY;
							tries_left_d = load_tries;
						end else begin
							if (!keep_q)
								cs_d = 1'b0;
							phase_d = PH_TRAIL;
						end
					end
				end
				PH_BUSY: begin
					tries_left_d = tries_dec;
					if (rx_byte != IDLE_BYTE || tries_dec == 8'd0) begin
						if (rx_byte == IDLE_BYTE)
							tmo_d = 1'b1;
						if (!keep_q)
							cs_d = 1'b0;
						phase_d = PH_TRAIL;
					end
				end
				PH_R2: begin
					if (byte_count_q == 3'd0) begin
						resp_value_d = {rx_byte, 8'h00};
						byte_count_d = 3'd1;
					end else begin
						resp_value_d = {resp_value_q[15:8], rx_byte};
						if (!keep_q)
							cs_d = 1'b0;
						phase_d = PH_TRAIL;
					end
				end
				PH_R7: begin
					if (byte_count_q == 3'd0)
						resp_value_d = R1_PREFIX | {8'h00, rx_byte};
					else
						resp_extra_d = {resp_extra_q[23:0], rx_byte};
					if (byte_count_q >= LAST_R7) begin
						if (!keep_q)
							cs_d = 1'b0;
						phase_d = PH_TRAIL;
					end else begin
						byte_count_d = bc_inc;
					end
				end
				PH_TRAIL: begin
					phase_d      = PH_IDLE;
					byte_count_d = 3'd0;
					emit_valid   = 1'b0;
					emit_done    = 1'b1;
				end
				default: begin
					// idle or unused code: rx is ignored
					phase_d    = PH_IDLE;
					emit_valid = 1'b0;
				end
			endcase
		end

		// fields without meaning read as zero
		res_d.tx_valid       = emit_valid;
		res_d.tx_byte        = emit_valid ? emit_byte : 8'h00;
		res_d.cs_low         = cs_d;
		res_d.done_res       = emit_done;
		res_d.timed_out      = emit_done ? tmo_d : 1'b0;
		res_d.response       = emit_done ? resp_value_d : 16'h0000;
		res_d.extra_response = emit_done ? resp_extra_d : 32'h0000_0000;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (cfg_wr_en) begin
			retry_limit_q <= cfg_wr_data;
		end
	end

	// command state update on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_count_q <= 3'd0;
			tries_left_q <= 8'd0;
			index_q      <= 6'd0;
			arg_q        <= 32'h0000_0000;
			crc_q        <= FILL_BYTE;
			kind_q       <= KIND_R1;
			keep_q       <= 1'b0;
			resp_value_q <= 16'h0000;
			resp_extra_q <= 32'h0000_0000;
			cs_q         <= 1'b0;
			tmo_q        <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			tries_left_q <= tries_left_d;
			index_q      <= index_d;
			arg_q        <= arg_d;
			crc_q        <= crc_d;
			kind_q       <= kind_d;
			keep_q       <= keep_d;
			resp_value_q <= resp_value_d;
			resp_extra_q <= resp_extra_d;
			cs_q         <= cs_d;
			tmo_q        <= tmo_d;
		end
	end

	// output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q)
				out_s1 <= skid_s1;
			else if (accept)
				out_s1 <= res_d;
		end else if (accept) begin
			skid_s1 <= res_d;
		end
	end

	assign tx_valid       = out_s1.tx_valid;
	assign tx_byte        = out_s1.tx_byte;
	assign cs_low         = out_s1.cs_low;
	assign done_res       = out_s1.done_res;
	assign timed_out      = out_s1.timed_out;
	assign response       = out_s1.response;
	assign extra_response = out_s1.extra_response;

endmodule

/* design/sdspi_checker.sv */
// port-level checker for the sd spi command engine and its bind
module sdspi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        tx_valid,
	input logic [7:0]  tx_byte,
	input logic        cs_low,
	input logic        done_res,
	input logic        timed_out,
	input logic [15:0] response,
	input logic [31:0] extra_response
);
	import sdspi_pkg::*;

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(done_res)
			&& $stable(response) && $stable(cs_low))
		else $error("stalled result changed");

	// no byte to send means a zero byte field
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == IDLE_BYTE)
		else $error("tx_byte set without tx_valid");

	// response fields only on the finishing item
	a_resp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> !timed_out && response == 16'h0000
			&& extra_response == 32'h0000_0000)
		else $error("response fields set before done");

	// the finishing item sends nothing
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !tx_valid)
		else $error("done result also requests a byte");

endmodule

bind sd_spi_command_engine_unit sdspi_checker u_sdspi_checker (.*);

/* tb/tb_sd_spi_command_engine_unit.sv */
// self-checking testbench for the sd spi command engine: queued byte events, predicted results
`timescale 1ns / 100ps

module tb_sd_spi_command_engine_unit;
	import sdspi_pkg::*;

	// one input transfer as it sits on the payload ports, in port order
	typedef struct packed {
		logic        cmd;
		logic [5:0]  idx;
		logic [31:0] arg;
		logic [7:0]  crc;
		logic        crc_auto;
		logic [1:0]  kind;
		logic        keep;
		logic [7:0]  rx;
	} spi_event_t;

	// receiver hold-off long enough for the skid stage to fill and stall the input
	localparam int LONG_HOLD = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = 1'b0;
	logic [5:0]  cmd_index = '0;
	logic [31:0] cmd_arg = '0;
	logic [7:0]  crc_byte = '0;
	logic        auto_crc = 1'b0;
	logic [1:0]  resp_kind = '0;
	logic        keep_cs_low = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        cs_low;
	logic        done_res;
	logic        timed_out;
	logic [15:0] response;
	logic [31:0] extra_response;

	sd_spi_command_engine_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.cmd_index      (cmd_index),
		.cmd_arg        (cmd_arg),
		.crc_byte       (crc_byte),
		.auto_crc       (auto_crc),
		.resp_kind      (resp_kind),
		.keep_cs_low    (keep_cs_low),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tx_valid       (tx_valid),
		.tx_byte        (tx_byte),
		.cs_low         (cs_low),
		.done_res       (done_res),
		.timed_out      (timed_out),
		.response       (response),
		.extra_response (extra_response)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// engine predictor: own copy of the command state and retry limit
	// ---------------------------------------------------------------
	logic [7:0]  retry_setting = RETRY_RESET;
	logic [3:0]  ph = PH_IDLE;
	logic [2:0]  byte_no = '0;
	logic [7:0]  tries = '0;
	logic [5:0]  idx_l = '0;
	logic [31:0] arg_l = '0;
	logic [7:0]  crc_l = FILL_BYTE;
	logic [1:0]  kind_l = KIND_R1;
	logic        keep_l = 1'b0;
	logic [15:0] resp_l = '0;
	logic [31:0] extra_l = '0;
	logic        cs_l = 1'b0;
	logic        tmo_l = 1'b0;

	spi_event_t pending_events[$];
	res_t       awaited_results[$];
	int         events_queued = 0;
	int         mismatches = 0;

	// a zero limit still allows one polling read
	function automatic logic [7:0] load_tries();
		return (retry_setting == 8'd0) ? 8'd1 : retry_setting;
	endfunction

	// command frame: token with index, argument msb first, then crc
	function automatic logic [7:0] frame_byte(input logic [2:0] n);
		if (n == 3'd0)
			return START_TOKEN | {2'b00, idx_l};
		if (n <= 3'd4)
			return 8'(arg_l >> (8 * (4 - n)));
		return crc_l;
	endfunction

	function automatic void enter_trail();
		if (!keep_l)
			cs_l = 1'b0;
		ph = PH_TRAIL;
	endfunction

	function automatic res_t predict_engine(input spi_event_t ev);
		res_t       r;
		logic       sends;
		logic [7:0] outb;
		logic       fin;
		sends = 1'b1;
		outb  = FILL_BYTE;
		fin   = 1'b0;
		if (ev.cmd == CMD_START) begin
			// a start always wins, even over a running command
			idx_l   = ev.idx;
			arg_l   = ev.arg;
			crc_l   = ev.crc_auto ? ((ev.idx == 6'd0) ? CRC_CMD0 : FILL_BYTE) : ev.crc;
			kind_l  = ev.kind;
			keep_l  = ev.keep;
			resp_l  = '0;
			extra_l = '0;
			tmo_l   = 1'b0;
			tries   = '0;
			cs_l    = 1'b1;
			ph      = PH_CMD;
			byte_no = '0;
			outb    = frame_byte(3'd0);
		end else begin
			case (ph)
				PH_CMD: begin
					byte_no = byte_no + 3'd1;
					if (byte_no <= LAST_FRAME)
						outb = frame_byte(byte_no);
					else
						ph = PH_FILL;
				end
				PH_FILL: begin
					byte_no = '0;
					if (kind_l == KIND_R1 || kind_l == KIND_R1B) begin
						ph    = PH_POLL;
						tries = load_tries();
					end else begin
						ph = (kind_l == KIND_R2) ? PH_R2 : PH_R7;
					end
				end
				PH_POLL: begin
					tries  = tries - 8'd1;
					resp_l = R1_PREFIX | {8'h00, ev.rx};
					if (ev.rx != FILL_BYTE || tries == 8'd0) begin
						if (ev.rx == FILL_BYTE)
							tmo_l = 1'b1;
						// r1b goes on to the busy poll even after a poll timeout
						if (kind_l == KIND_R1B) begin
							ph    = PH_BUSY;
							tries = load_tries();
						end else begin
							enter_trail();
						end
					end
				end
				PH_BUSY: begin
					tries = tries - 8'd1;
					if (ev.rx != IDLE_BYTE || tries == 8'd0) begin
						if (ev.rx == IDLE_BYTE)
							tmo_l = 1'b1;
						enter_trail();
					end
				end
				PH_R2: begin
					if (byte_no == 3'd0) begin
						resp_l  = {ev.rx, 8'h00};
						byte_no = 3'd1;
					end else begin
						resp_l = {resp_l[15:8], ev.rx};
						enter_trail();
					end
				end
				PH_R7: begin
					if (byte_no == 3'd0)
						resp_l = R1_PREFIX | {8'h00, ev.rx};
					else
						extra_l = {extra_l[23:0], ev.rx};
					if (byte_no >= LAST_R7)
						enter_trail();
					else
						byte_no = byte_no + 3'd1;
				end
				PH_TRAIL: begin
					ph      = PH_IDLE;
					byte_no = '0;
					sends   = 1'b0;
					fin     = 1'b1;
				end
				default: begin
					// rx with nothing running is dropped
					ph    = PH_IDLE;
					sends = 1'b0;
				end
			endcase
		end
		r.tx_valid       = sends;
		r.tx_byte        = sends ? outb : IDLE_BYTE;
		r.cs_low         = cs_l;
		r.done_res       = fin;
		r.timed_out      = fin & tmo_l;
		r.response       = fin ? resp_l : 16'h0000;
		r.extra_response = fin ? extra_l : 32'h0000_0000;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function automatic spi_event_t start_ev(input logic [5:0] idx, input logic [31:0] arg,
			input logic [7:0] crc, input logic crc_auto, input logic [1:0] kind,
			input logic keep);
		spi_event_t  e;
		logic [63:0] junk;
		junk       = {$urandom, $urandom};
		e          = junk[$bits(spi_event_t)-1:0];
		e.cmd      = CMD_START;
		e.idx      = idx;
		e.arg      = arg;
		e.crc      = crc;
		e.crc_auto = crc_auto;
		e.kind     = kind;
		e.keep     = keep;
		return e;
	endfunction

	// command fields carry junk on rx transfers, the engine must ignore them
	function automatic spi_event_t rx_ev(input logic [7:0] b);
		spi_event_t  e;
		logic [63:0] junk;
		junk  = {$urandom, $urandom};
		e     = junk[$bits(spi_event_t)-1:0];
		e.cmd = CMD_RX;
		e.rx  = b;
		return e;
	endfunction

	function automatic void queue_event(input spi_event_t e);
		pending_events.push_back(e);
		events_queued++;
	endfunction

	// one well-formed command with random content; tmo_mask bit 0 runs the r1 poll out,
	// bit 1 runs the busy poll out; a nonzero cut keeps only the first cut transfers
	function automatic void add_command(input logic [1:0] kind, input logic [1:0] tmo_mask,
			input int cut);
		spi_event_t seq[$];
		int         lim;
		int         shortest;
		int         n;
		logic [5:0] idx;
		logic [7:0] crc;
		logic       crc_auto;
		logic       keep;
		lim      = (retry_setting == 8'd0) ? 1 : retry_setting;
		shortest = (lim - 1 < 3) ? lim - 1 : 3;
		idx      = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
		crc      = 8'($urandom_range(0, 255));
		crc_auto = 1'($urandom_range(0, 1));
		keep     = 1'($urandom_range(0, 1));
		seq.push_back(start_ev(idx, $urandom, crc, crc_auto, kind, keep));
		// frame bytes and filler: the card answers with noise
		repeat (7)
			seq.push_back(rx_ev(8'($urandom_range(0, 255))));
		if (kind == KIND_R1 || kind == KIND_R1B) begin
			if (tmo_mask[0]) begin
				repeat (lim)
					seq.push_back(rx_ev(FILL_BYTE));
			end else begin
				n = $urandom_range(0, shortest);
				if (lim <= 16 && $urandom_range(0, 7) == 0)
					n = lim - 1;
				repeat (n)
					seq.push_back(rx_ev(FILL_BYTE));
				seq.push_back(rx_ev(8'($urandom_range(0, 254))));
			end
			if (kind == KIND_R1B) begin
				if (tmo_mask[1]) begin
					repeat (lim)
						seq.push_back(rx_ev(IDLE_BYTE));
				end else begin
					n = $urandom_range(0, shortest);
					if (lim <= 16 && $urandom_range(0, 7) == 0)
						n = lim - 1;
					repeat (n)
						seq.push_back(rx_ev(IDLE_BYTE));
					seq.push_back(rx_ev(8'($urandom_range(1, 255))));
				end
			end
		end else begin
			repeat ((kind == KIND_R2) ? 2 : 5)
				seq.push_back(rx_ev(8'($urandom_range(0, 255))));
		end
		// trailing byte that closes the sequence
		seq.push_back(rx_ev(8'($urandom_range(0, 255))));
		foreach (seq[i])
			if (cut == 0 || i < cut)
				queue_event(seq[i]);
	endfunction

	// ---------------------------------------------------------------
	// driver: offers queued events, predicts on every accepted transfer
	// ---------------------------------------------------------------
	int tx_gap = 0;
	bit tx_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap   <= 0;
		end else begin
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_engine({cmd, cmd_index, cmd_arg, crc_byte,
					auto_crc, resp_kind, keep_cs_low, rx_byte}));
			// payload only moves once the current transfer is done
			if (!in_valid || !in_stall) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (pending_events.size() != 0) begin
					{cmd, cmd_index, cmd_arg, crc_byte, auto_crc, resp_kind, keep_cs_low,
						rx_byte} <= pending_events.pop_front();
					in_valid <= 1'b1;
					// now and then switch between back-to-back and gapped traffic
					if ($urandom_range(0, 29) == 0)
						tx_burst = !tx_burst;
					tx_gap <= tx_burst ? 0 : $urandom_range(0, 17);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: random back-pressure, compares each result transfer
	// ---------------------------------------------------------------
	int stall_left = 0;
	int hold_next;
	int results_seen = 0;
	bit rx_burst = 1'b0;

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void compare_result(input res_t got);
		res_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: result with nothing expected, expected none, got %h", $time, got);
			mismatches++;
		end else begin
			want = awaited_results.pop_front();
			check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
			check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
			check_field("cs_low", 32'(want.cs_low), 32'(got.cs_low));
			check_field("done_res", 32'(want.done_res), 32'(got.done_res));
			check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
			check_field("response", 32'(want.response), 32'(got.response));
			check_field("extra_response", want.extra_response, got.extra_response);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				compare_result({tx_valid, tx_byte, cs_low, done_res, timed_out, response,
					extra_response});
				// twice in the run the receiver goes quiet while the sender keeps pushing
				if (results_seen == 150 || results_seen == 700) begin
					hold_next = LONG_HOLD;
				end else begin
					if ($urandom_range(0, 29) == 0)
						rx_burst = !rx_burst;
					hold_next = rx_burst ? 0 : $urandom_range(0, 17);
				end
				results_seen++;
			end else begin
				hold_next = (stall_left > 0) ? stall_left - 1 : 0;
			end
			stall_left <= hold_next;
			out_stall  <= (hold_next != 0);
		end
	end

	// ---------------------------------------------------------------
	// sequencing: reset, directed commands, then one phase per retry limit
	// ---------------------------------------------------------------
	// every result is back, then a few cycles so the engine is surely idle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_retry(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		retry_setting = v;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] retry_plan [0:6];
		int         phase_end;
		int         pick;
		logic [1:0] kind;
		retry_plan[0] = 8'd1;
		retry_plan[1] = 8'd0;
		retry_plan[2] = 8'd255;
		retry_plan[3] = 8'd4;
		retry_plan[4] = 8'($urandom_range(2, 12));
		retry_plan[5] = 8'($urandom_range(2, 12));
		retry_plan[6] = 8'd3;

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// rx with no command running
		queue_event(rx_ev(FILL_BYTE));
		// command 0 with all-ones argument and automatic crc, one poll miss then 0x00
		queue_event(start_ev(6'd0, 32'hFFFF_FFFF, 8'h00, 1'b1, KIND_R1, 1'b0));
		repeat (7)
			queue_event(rx_ev(8'hA5));
		queue_event(rx_ev(FILL_BYTE));
		queue_event(rx_ev(IDLE_BYTE));
		queue_event(rx_ev(8'h5A));
		// highest index, zero argument, abandoned two bytes in by the next start
		queue_event(start_ev(6'd63, 32'h0000_0000, 8'hFF, 1'b1, KIND_R7, 1'b1));
		queue_event(rx_ev(IDLE_BYTE));
		queue_event(rx_ev(FILL_BYTE));
		// explicit crc, r2 with chip select held
		queue_event(start_ev(6'd8, 32'h1A2B_3C4D, 8'h87, 1'b0, KIND_R2, 1'b1));
		repeat (7)
			queue_event(rx_ev(8'($urandom_range(0, 255))));
		queue_event(rx_ev(FILL_BYTE));
		queue_event(rx_ev(IDLE_BYTE));
		queue_event(rx_ev(8'h3C));
		wait_idle();

		for (int p = 0; p < 7; p++) begin
			write_retry(retry_plan[p]);
			if (retry_setting <= 8'd16) begin
				// poll timeout, busy timeout, and both in one r1b
				add_command(KIND_R1, 2'b01, 0);
				add_command(KIND_R1B, 2'b10, 0);
				add_command(KIND_R1B, 2'b11, 0);
			end else begin
				// a long limit is run out once, on the poll of an r1b
				add_command(KIND_R1B, 2'b01, 0);
			end
			add_command(KIND_R7, 2'b00, 0);
			phase_end = events_queued + 20;
			while (events_queued < phase_end) begin
				pick = $urandom_range(0, 99);
				kind = 2'($urandom_range(0, 3));
				if (pick < 8 && retry_setting <= 8'd16) begin
					add_command($urandom_range(0, 1) ? KIND_R1B : KIND_R1,
						2'($urandom_range(1, 3)), 0);
				end else if (pick < 80) begin
					add_command(kind, 2'b00, 0);
				end else if (pick < 92) begin
					// broken off part way, the next start takes over
					add_command(kind, 2'b00, $urandom_range(1, 12));
				end else begin
					// stray rx bytes, mostly dropped by an idle engine
					repeat ($urandom_range(1, 3))
						pending_events.push_back(rx_ev(8'($urandom_range(0, 255))));
				end
			end
			wait_idle();
		end

		repeat (10)
			@(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("%0t: run did not complete in time", $time);
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
design/sdspi_pkg.sv
design/sd_spi_command_engine_unit.sv
design/sdspi_checker.sv
tb/tb_sd_spi_command_engine_unit.sv
